// ----- sv/mdc_pkg.sv -----
// Shared command and status types for the determinant controller and datapath.
package mdc_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_wr;   // Write the size register and restart the load.
        logic load;     // Store one element and advance the load position.
        logic init;     // Clear the accumulator and the column tuple.
        logic pinit;    // Start a new product term.
        logic rd;       // Read the next factor of the term.
        logic mul;      // One limb step of the term multiply.
        logic acc;      // Add or subtract the finished term.
        logic inc;      // Step to the next column tuple.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_last;  // The element position is the last one of the matrix.
        logic is_perm;    // The current column tuple is a permutation.
        logic tup_last;   // The current column tuple is the final one.
        logic limb_last;  // The multiply is on its top limb.
        logic fac_last;   // The current factor is the last row of the term.
    } t_sts;

    // Widths of one matrix element (also one multiply limb), of the size register and of the determinant.
    localparam int ELEM_W = 16;
    localparam int SIZE_W = 3;
    localparam int DET_W  = 64;

endpackage

// ----- sv/mdc_ctrl.sv -----
// Sequencer for loading and for the permutation walk of the determinant.
module mdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_cfg_valid,
    input  mdc_pkg::t_sts i_sts,
    output mdc_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_cfg_ready,
    output logic          o_valid
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_PINIT = 9'b000001000,
        S_RD    = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_ADV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_wr = 1'b1;
                end else if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.load_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.is_perm ? S_PINIT : S_ADV;
            end
            S_PINIT: begin
                o_cmd.pinit = 1'b1;
                n_state     = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_sts.limb_last) begin
                    n_state = i_sts.fac_last ? S_ACC : S_RD;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_ADV;
            end
            S_ADV: begin
                if (i_sts.tup_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A size write is taken only when idle, and it holds off an element in that cycle.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE) || i_cfg_valid;
    assign o_valid     = (r_state == S_DONE);

`ifndef SYNTHESIS
    // A result strobe lasts one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    // After a result the block is ready for the next matrix.
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (r_state == S_IDLE)) else $error("busy after result");

    // An element that does not complete the matrix keeps the block idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_cfg_valid && !i_sts.load_last) |=> (r_state == S_IDLE))
        else $error("busy during load");
`endif

endmodule

// ----- sv/mdc_dp.sv -----
// Datapath: element store, column tuple walker, limb multiplier and accumulator.
module mdc_dp #(
    parameter int MAX_SIZE = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mdc_pkg::t_cmd                    i_cmd,
    input  logic [mdc_pkg::SIZE_W-1:0]       i_cfg_data,
    input  logic signed [mdc_pkg::ELEM_W-1:0] i_element_value,
    output mdc_pkg::t_sts                    o_sts,
    output logic signed [mdc_pkg::DET_W-1:0] o_determinant_value,
    output logic                             o_overflow_flag
);

    localparam int EW    = mdc_pkg::ELEM_W;
    localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = EW * MAX_SIZE;
    localparam int ACC_W = (PW + 12 > 66) ? PW + 12 : 66;
    localparam int DW    = mdc_pkg::DET_W;

    logic [mdc_pkg::SIZE_W-1:0] r_size;
    logic [NW-1:0]              w_n;
    logic [CW-1:0]              w_nm1;
    logic [CW-1:0]              r_lrow, r_lcol;
    logic [EW-1:0]              r_mem [DEPTH];
    logic [EW-1:0]              r_rdata;
    logic [CW-1:0]              r_dig [MAX_SIZE];
    logic [CW-1:0]              n_dig [MAX_SIZE];
    logic [CW-1:0]              r_fac, r_limb;
    logic [PW-1:0]              r_prod;
    logic [EW:0]                r_carry;
    logic                       r_psign;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       w_perm, w_par, w_last, w_cy;
    logic [EW:0]                w_ext, w_mag;
    logic [2*EW:0]              w_step;
    logic [AW-1:0]              w_waddr, w_raddr;
    logic [ACC_W-DW:0]          w_hi;

    // Matrix order from the size register, clamped to 1..MAX_SIZE.
    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (32'(r_size) > MAX_SIZE) begin
            w_n = NW'(MAX_SIZE);
        end else begin
            w_n = NW'(r_size);
        end
    end
    assign w_nm1 = CW'(w_n - NW'(1));

    // Size register; a write restarts the load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= mdc_pkg::SIZE_W'(3);
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (i_cmd.cfg_wr) begin
            r_size <= i_cfg_data;
            r_lrow <= '0;
            r_lcol <= '0;
        end else if (i_cmd.load) begin
            if (r_lcol == w_nm1) begin
                r_lcol <= '0;
                r_lrow <= (r_lrow == w_nm1) ? '0 : r_lrow + CW'(1);
            end else begin
                r_lcol <= r_lcol + CW'(1);
            end
        end
    end
    assign o_sts.load_last = (r_lrow == w_nm1) && (r_lcol == w_nm1);

    // Element store with a row stride of MAX_SIZE.
    assign w_waddr = AW'(AW'(r_lrow) * AW'(MAX_SIZE)) + AW'(r_lcol);
    assign w_raddr = AW'(AW'(r_fac) * AW'(MAX_SIZE)) + AW'(r_dig[r_fac]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[w_waddr] <= i_element_value;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Permutation test and inversion parity of the column tuple.
    always_comb begin
        w_perm = 1'b1;
        w_par  = 1'b0;
        w_last = 1'b1;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (i < 32'(w_n)) begin
                if (r_dig[i] != w_nm1) begin
                    w_last = 1'b0;
                end
                for (int j = i + 1; j < MAX_SIZE; j++) begin
                    if (j < 32'(w_n)) begin
                        if (r_dig[i] == r_dig[j]) begin
                            w_perm = 1'b0;
                        end
                        if (r_dig[i] > r_dig[j]) begin
                            w_par = ~w_par;
                        end
                    end
                end
            end
        end
    end
    assign o_sts.is_perm  = w_perm;
    assign o_sts.tup_last = w_last;

    // Odometer step over the first n digits.
    always_comb begin
        w_cy = 1'b1;
        for (int i = 0; i < MAX_SIZE; i++) begin
            n_dig[i] = r_dig[i];
            if (i < 32'(w_n) && w_cy) begin
                if (r_dig[i] == w_nm1) begin
                    n_dig[i] = '0;
                end else begin
                    n_dig[i] = r_dig[i] + CW'(1);
                    w_cy     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (i_cmd.init) begin
                r_dig[i] <= '0;
            end else if (i_cmd.inc) begin
                r_dig[i] <= n_dig[i];
            end
        end
    end

    // Magnitude of the fetched element and one 16-bit limb product.
    assign w_ext  = {r_rdata[EW-1], r_rdata};
    assign w_mag  = r_rdata[EW-1] ? (~w_ext + (EW+1)'(1)) : w_ext;
    assign w_step = (2*EW+1)'(r_prod[EW-1:0]) * (2*EW+1)'(w_mag)
                  + (2*EW+1)'(r_carry);

    // Term product: unsigned magnitude rotated limb by limb, sign kept aside.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pinit) begin
            r_prod  <= PW'(1);
            r_psign <= w_par;
            r_fac   <= '0;
        end else if (i_cmd.rd) begin
            r_carry <= '0;
            r_limb  <= '0;
        end else if (i_cmd.mul) begin
            r_prod  <= (r_prod >> EW) | (PW'(w_step[EW-1:0]) << (PW - EW));
            r_carry <= w_step[2*EW:EW];
            if (r_limb == CW'(MAX_SIZE - 1)) begin
                r_limb  <= '0;
                r_psign <= r_psign ^ r_rdata[EW-1];
                r_fac   <= r_fac + CW'(1);
            end else begin
                r_limb <= r_limb + CW'(1);
            end
        end
    end
    assign o_sts.limb_last = (r_limb == CW'(MAX_SIZE - 1));
    assign o_sts.fac_last  = (r_fac == w_nm1);

    // Signed sum of the terms.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_psign ? r_acc - $signed(ACC_W'(r_prod))
                             : r_acc + $signed(ACC_W'(r_prod));
        end
    end

    // Saturation to 64 bits.
    assign w_hi = r_acc[ACC_W-1:DW-1];
    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            o_determinant_value = r_acc[DW-1:0];
            o_overflow_flag     = 1'b0;
        end else begin
            o_determinant_value = r_acc[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                                 : {1'b0, {(DW-1){1'b1}}};
            o_overflow_flag     = 1'b1;
        end
    end

endmodule

// ----- sv/matrix_determinant_cofactor_top.sv -----
// Top level of the exact determinant block: controller plus datapath.
// Elements are taken one per cycle in row-major order while o_busy is low.
// The last element of an n-by-n matrix starts the computation: the block
// walks all n^n column tuples, and for each permutation multiplies its n
// elements, limb by limb for each factor, on one 16x17 limb multiplier.
// It stays busy through the walk, then shows the saturated determinant for
// exactly one cycle with o_valid high.
// The receiver cannot stall, so it must take the result in that cycle.
// A size write restarts the load and is taken only while the block is idle;
// o_busy is high while it is offered, so an element offered with it waits.
module matrix_determinant_cofactor_top #(
    parameter int MAX_SIZE = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [mdc_pkg::ELEM_W-1:0] i_element_value,
    output logic                             o_valid,
    output logic signed [mdc_pkg::DET_W-1:0] o_determinant_value,
    output logic                             o_overflow_flag,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mdc_pkg::SIZE_W-1:0]       i_cfg_data
);

    mdc_pkg::t_cmd w_cmd;
    mdc_pkg::t_sts w_sts;

    mdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid)
    );

    mdc_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg_data          (i_cfg_data),
        .i_element_value     (i_element_value),
        .o_sts               (w_sts),
        .o_determinant_value (o_determinant_value),
        .o_overflow_flag     (o_overflow_flag)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the permutation-sum determinant block.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_SIZE    = 4;
    localparam int SETTLE_CYC  = 8;
    localparam int TAIL_CYC    = 1200;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int QUIET_ITEMS = 150;

    typedef enum logic {JOB_ELEM, JOB_SIZE} t_job_kind;

    typedef struct {
        t_job_kind   kind;
        logic [15:0] value;
        int          gap;
    } t_job;

    typedef struct {
        logic signed [63:0] det;
        logic               ovf;
    } t_det;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic signed [15:0]        i_element_value;
    logic                      o_valid;
    logic signed [63:0]        o_determinant_value;
    logic                      o_overflow_flag;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [mdc_pkg::SIZE_W-1:0] i_cfg_data;

    // Stimulus and expected results.
    t_job job_q[$];
    t_det det_q[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   job_total   = 0;

    // Predictor state.
    logic signed [15:0] elem_store[MAX_SIZE*MAX_SIZE];
    int                 load_pos  = 0;
    logic [2:0]         size_reg  = 3'd3;

    // Handshake flags sampled at the rising edge.
    logic elem_taken = 1'b0;
    logic size_taken = 1'b0;

    matrix_determinant_cofactor_top #(.MAX_SIZE(MAX_SIZE)) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_element_value     (i_element_value),
        .o_valid             (o_valid),
        .o_determinant_value (o_determinant_value),
        .o_overflow_flag     (o_overflow_flag),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    // Clock, 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Matrix order that a size register value selects.
    function automatic int order_of(input logic [2:0] sz);
        if (sz == 0) return 1;
        if (sz > MAX_SIZE) return MAX_SIZE;
        return sz;
    endfunction

    // Exact determinant of the loaded matrix as a sum over all permutations.
    function automatic logic signed [127:0] exact_det(input int n);
        logic signed [127:0] sum;
        logic signed [127:0] prod;
        logic signed [127:0] ev;
        int col[MAX_SIZE];
        int tuples, t, r, k, used, inv;
        bit ok;
        sum = 0;
        tuples = 1;
        for (r = 0; r < n; r++) tuples *= n;
        for (t = 0; t < tuples; t++) begin
            k = t;
            used = 0;
            ok = 1;
            for (r = 0; r < n; r++) begin
                col[r] = k % n;
                k = k / n;
                if (used[col[r]]) ok = 0;
                used[col[r]] = 1'b1;
            end
            if (ok) begin
                prod = 1;
                inv = 0;
                for (r = 0; r < n; r++) begin
                    ev = elem_store[r*n + col[r]];
                    prod = prod * ev;
                    for (k = r + 1; k < n; k++)
                        if (col[r] > col[k]) inv++;
                end
                if (inv % 2) sum = sum - prod;
                else sum = sum + prod;
            end
        end
        return sum;
    endfunction

    // Store one accepted element; a completed matrix yields an expected result.
    task automatic take_element(input logic signed [15:0] v);
        int n;
        logic signed [127:0] d;
        t_det res;
        n = order_of(size_reg);
        if (load_pos >= n*n) load_pos = 0;
        elem_store[load_pos] = v;
        load_pos++;
        if (load_pos == n*n) begin
            load_pos = 0;
            d = exact_det(n);
            if (d > 128'sh7FFF_FFFF_FFFF_FFFF) begin
                res.det = 64'h7FFF_FFFF_FFFF_FFFF;
                res.ovf = 1'b1;
            end else if (d < -128'sh8000_0000_0000_0000) begin
                res.det = 64'h8000_0000_0000_0000;
                res.ovf = 1'b1;
            end else begin
                res.det = d[63:0];
                res.ovf = 1'b0;
            end
            det_q.push_back(res);
        end
    endtask

    // Queue helpers for building the stimulus.
    task automatic add_elem(input logic [15:0] v, input int gap);
        t_job j;
        j.kind = JOB_ELEM;
        j.value = v;
        j.gap = gap;
        job_q.push_back(j);
        job_total++;
    endtask

    task automatic add_size(input logic [2:0] sz);
        t_job j;
        j.kind = JOB_SIZE;
        j.value = {13'd0, sz};
        j.gap = 0;
        job_q.push_back(j);
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 10);
        return 0;
    endfunction

    // Random element: full range, small values, or extremes.
    function automatic logic [15:0] rand_elem(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 14)) - 7);
            default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    // Monitor: record handshakes, update the predictor, check results.
    always @(posedge i_clk) begin
        t_det e;
        cycle_count <= cycle_count + 1;
        elem_taken = i_rst_n && i_start && !o_busy;
        size_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (size_taken) begin
            size_reg = i_cfg_data;
            load_pos = 0;
        end
        if (elem_taken) take_element(i_element_value);
        if (i_rst_n && o_valid) begin
            if (det_q.size() == 0) begin
                $error("determinant_value: unexpected result %0d", o_determinant_value);
                error_count++;
            end else begin
                e = det_q.pop_front();
                if (o_determinant_value !== e.det) begin
                    $error("determinant_value: expected %0d, actual %0d",
                           e.det, o_determinant_value);
                    error_count++;
                end
                if (o_overflow_flag !== e.ovf) begin
                    $error("overflow_flag: expected %0d, actual %0d",
                           e.ovf, o_overflow_flag);
                    error_count++;
                end
            end
        end
    end

    // Driver: issues queued items and size writes at the falling edge.
    always @(negedge i_clk) begin
        logic        nstart;
        logic        ncfg;
        logic [15:0] nval;
        logic [2:0]  ndata;
        static int   gap_left = 0;
        static int   settle = SETTLE_CYC;
        nstart = i_start;
        ncfg = i_cfg_valid;
        nval = i_element_value;
        ndata = i_cfg_data;
        if (elem_taken) nstart = 1'b0;
        if (size_taken) ncfg = 1'b0;
        if (i_rst_n && !nstart && !ncfg) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (job_q.size() > 0) begin
                if (job_q[0].kind == JOB_ELEM) begin
                    if (job_q[0].gap > 0) begin
                        gap_left = job_q[0].gap - 1;
                        job_q[0].gap = 0;
                    end else begin
                        nstart = 1'b1;
                        nval = job_q[0].value;
                        void'(job_q.pop_front());
                    end
                end else if (det_q.size() == 0 && !o_busy) begin
                    // Let the block settle before touching the size register.
                    if (settle > 0) begin
                        settle--;
                    end else begin
                        ncfg = 1'b1;
                        ndata = job_q[0].value[2:0];
                        void'(job_q.pop_front());
                        settle = SETTLE_CYC;
                    end
                end else begin
                    settle = SETTLE_CYC;
                end
            end
        end
        i_start <= nstart;
        i_cfg_valid <= ncfg;
        i_element_value <= nval;
        i_cfg_data <= ndata;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus build, reset and end of run.
    initial begin
        int sz, mats, m, k, n, style, i;
        logic [15:0] hsign[16];
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_element_value = '0;
        i_cfg_data = '0;

        // Order one at the extremes, with size zero treated as order one.
        add_size(3'd1);
        add_elem(16'h7FFF, 0);
        add_elem(16'h8000, 2);
        add_size(3'd0);
        add_elem(16'h0000, 0);
        // Order two with extreme entries.
        add_size(3'd2);
        add_elem(16'h8000, 0); add_elem(16'h8000, 0);
        add_elem(16'h7FFF, 0); add_elem(16'h8000, 0);
        // Order four Hadamard pattern at -32768: positive overflow.
        hsign = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                  16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
        add_size(3'd4);
        for (i = 0; i < 16; i++) add_elem(hsign[i], 0);
        // The same pattern with rows 0/1 and rows 2/3 swapped keeps the sign.
        for (i = 0; i < 16; i++) add_elem(hsign[i ^ 4], 0);
        // Size above the maximum saturates to order four.
        add_size(3'd7);
        for (i = 0; i < 16; i++) add_elem((i % 5 == 0) ? 16'h8000 : 16'h0000, 0);
        // A size write in the middle of a load discards the partial matrix.
        add_size(3'd3);
        add_elem(16'h1234, 0); add_elem(16'hFFFF, 0);
        add_size(3'd3);

        // Random phases of mostly well-formed matrices.
        while (job_total < 1050) begin
            case ($urandom_range(0, 9))
                0: sz = 1;
                1, 2: sz = 2;
                3, 4, 5: sz = 3;
                6, 7: sz = 4;
                default: sz = $urandom_range(0, 7);
            endcase
            add_size(3'(sz));
            n = order_of(3'(sz));
            mats = $urandom_range(2, 12);
            for (m = 0; m < mats; m++) begin
                style = $urandom_range(0, 3);
                for (k = 0; k < n*n; k++) add_elem(rand_elem(style), rand_gap());
            end
            // Sometimes leave a broken, partial matrix behind.
            if ($urandom_range(0, 3) == 0 && n > 1) begin
                style = $urandom_range(1, n*n - 1);
                for (k = 0; k < style; k++)
                    add_elem(16'($urandom), rand_gap());
            end
        end
        // The last part of the run has no idling.
        k = 0;
        for (i = job_q.size() - 1; i >= 0 && k < QUIET_ITEMS; i--) begin
            job_q[i].gap = 0;
            k++;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (job_q.size() > 0 || i_start || i_cfg_valid || det_q.size() > 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (error_count == 0 && det_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
